[rtl/hftf_pkg.sv]
// ----------------------------------------------------------------------------
// hftf_pkg
// Shared types, sizes, codes and the static header field table for the
// header field table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hftf_pkg;

   // sizing
   localparam int ARENA_BYTES    = 4096;
   localparam int MAX_ENTRIES    = 128;
   localparam int ARENA_AW       = $clog2(ARENA_BYTES);
   localparam int ENTRY_AW       = $clog2(MAX_ENTRIES);
   localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);
   localparam int SIZE_W         = ARENA_AW + 1;
   localparam int LEN_W          = 13;
   localparam int TOTAL_W        = 14;
   localparam int COST_W         = TOTAL_W + 1;
   localparam int SUM_W          = ((SIZE_W > COST_W) ? SIZE_W : COST_W) + 1;
   localparam int SLOT_W         = (CNT_W > 10) ? CNT_W : 10;
   localparam int ENTRY_OVERHEAD = 32;
   localparam int STATIC_COUNT   = 61;
   localparam int FIRST_DYNAMIC  = 62;

   // static table strings
   localparam int NAME_CHARS = 27;
   localparam int NAME_BITS  = NAME_CHARS * 8;
   localparam int SLEN_W     = $clog2(NAME_CHARS + 1);

   // command codes
   localparam logic [2:0] CMD_LOOKUP    = 3'd0;
   localparam logic [2:0] CMD_READ      = 3'd1;
   localparam logic [2:0] CMD_INS_BEGIN = 3'd2;
   localparam logic [2:0] CMD_INS_BYTE  = 3'd3;
   localparam logic [2:0] CMD_RESIZE    = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_INDEX = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_DROPPED   = 3'd3;
   localparam logic [2:0] ST_SEQUENCE  = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DUSE,
      S_AUSE,
      S_EVICT,
      S_EV_APPLY,
      S_COMMIT,
      S_RESP
   } state_type;

   // dynamic entry descriptor, name_addr is a ring address in the arena
   typedef struct packed {
      logic [ARENA_AW-1:0] name_addr;
      logic [LEN_W-1:0]    name_bytes;
      logic [LEN_W-1:0]    value_bytes;
   } desc_type;

   typedef struct packed {
      logic                en;
      logic [ARENA_AW-1:0] addr;
      logic [7:0]          data;
   } arena_wr_type;

   typedef struct packed {
      logic                en;
      logic [ENTRY_AW-1:0] addr;
      desc_type            data;
   } desc_wr_type;

   // static names, zero padded on the high side
   function automatic logic [NAME_BITS-1:0] rom_name(input logic [5:0] k);
      logic [NAME_BITS-1:0] s;
      s = '0;
      case (k)
         6'd0:  s = ":authority";
         6'd1:  s = ":method";
         6'd2:  s = ":method";
         6'd3:  s = ":path";
         6'd4:  s = ":path";
         6'd5:  s = ":scheme";
         6'd6:  s = ":scheme";
         6'd7:  s = ":status";
         6'd8:  s = ":status";
         6'd9:  s = ":status";
         6'd10: s = ":status";
         6'd11: s = ":status";
         6'd12: s = ":status";
         6'd13: s = ":status";
         6'd14: s = "accept-charset";
         6'd15: s = "accept-encoding";
         6'd16: s = "accept-language";
         6'd17: s = "accept-ranges";
         6'd18: s = "accept";
         6'd19: s = "access-control-allow-origin";
         6'd20: s = "age";
         6'd21: s = "allow";
         6'd22: s = "authorization";
         6'd23: s = "cache-control";
         6'd24: s = "content-disposition";
         6'd25: s = "content-encoding";
         6'd26: s = "content-language";
         6'd27: s = "content-length";
         6'd28: s = "content-location";
         6'd29: s = "content-range";
         6'd30: s = "content-type";
         6'd31: s = "cookie";
         6'd32: s = "date";
         6'd33: s = "etag";
         6'd34: s = "expect";
         6'd35: s = "expires";
         6'd36: s = "from";
         6'd37: s = "host";
         6'd38: s = "if-match";
         6'd39: s = "if-modified-since";
         6'd40: s = "if-none-match";
         6'd41: s = "if-range";
         6'd42: s = "if-unmodified-since";
         6'd43: s = "last-modified";
         6'd44: s = "link";
         6'd45: s = "location";
         6'd46: s = "max-forwards";
         6'd47: s = "proxy-authenticate";
         6'd48: s = "proxy-authorization";
         6'd49: s = "range";
         6'd50: s = "referer";
         6'd51: s = "refresh";
         6'd52: s = "retry-after";
         6'd53: s = "server";
         6'd54: s = "set-cookie";
         6'd55: s = "strict-transport-security";
         6'd56: s = "transfer-encoding";
         6'd57: s = "user-agent";
         6'd58: s = "vary";
         6'd59: s = "via";
         6'd60: s = "www-authenticate";
         default: s = '0;
      endcase
      return s;
   endfunction

   // static values, most are empty
   function automatic logic [NAME_BITS-1:0] rom_value(input logic [5:0] k);
      logic [NAME_BITS-1:0] s;
      s = '0;
      case (k)
         6'd1:  s = "GET";
         6'd2:  s = "POST";
         6'd3:  s = "/";
         6'd4:  s = "/index.html";
         6'd5:  s = "http";
         6'd6:  s = "https";
         6'd7:  s = "200";
         6'd8:  s = "204";
         6'd9:  s = "206";
         6'd10: s = "304";
         6'd11: s = "400";
         6'd12: s = "404";
         6'd13: s = "500";
         6'd15: s = "gzip, deflate";
         default: s = '0;
      endcase
      return s;
   endfunction

   // string length as count of non-zero characters
   function automatic logic [SLEN_W-1:0] str_len(input logic [NAME_BITS-1:0] s);
      logic [SLEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (s[i*8 +: 8] != 8'd0) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

   // character at position pos, first character sits in the highest used byte
   function automatic logic [7:0] str_byte(input logic [NAME_BITS-1:0] s,
                                           input logic [SLEN_W-1:0] len,
                                           input logic [SLEN_W-1:0] pos);
      logic [SLEN_W-1:0] sel;
      sel = len - 1'b1 - pos;
      return s[sel*8 +: 8];
   endfunction

endpackage

`default_nettype wire

[rtl/hftf_arena.sv]
// ----------------------------------------------------------------------------
// hftf_arena
// Byte arena for dynamic entry names and values, used as a ring.
// ----------------------------------------------------------------------------
`default_nettype none

module hftf_arena (
   input  wire logic                         clock,
   input  wire hftf_pkg::arena_wr_type       wr,
   input  wire logic [hftf_pkg::ARENA_AW-1:0] rd_addr,
   output logic [7:0]                        rd_data
);
   import hftf_pkg::*;

   logic [7:0] mem [ARENA_BYTES];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/hftf_desc.sv]
// ----------------------------------------------------------------------------
// hftf_desc
// Descriptor ring for dynamic entries: arena address and lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module hftf_desc (
   input  wire logic                          clock,
   input  wire hftf_pkg::desc_wr_type         wr,
   input  wire logic [hftf_pkg::ENTRY_AW-1:0] rd_addr,
   output hftf_pkg::desc_type                 rd_data
);
   import hftf_pkg::*;

   desc_type mem [MAX_ENTRIES];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/header_field_table_fifo.sv]
// ----------------------------------------------------------------------------
// header_field_table_fifo
// Header field table engine: static table ahead of a size bounded dynamic
// table kept as a descriptor ring over a byte ring arena.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    command and operands
//  rsp      out        rsp_tvalid/tready    status, lengths, byte
//
//  Static lookup or read byte: IDLE, EXEC, RESP; dynamic lookup adds DUSE, read
//  DUSE and AUSE. Insert byte, bad or out of sequence commands, oversized resize:
//  IDLE, EXEC, RESP. Resize and insert begin add EVICT, a stored insert COMMIT,
//  plus EV_APPLY and EVICT per entry evicted for room, EV_APPLY at full count.
//  Reset empties the table; memory contents need no clearing.
//  A stalled response holds the sequencer in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

module header_field_table_fifo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] command, [12:3] entry_index, [13] part_select, [25:14] byte_position,
   // [38:26] name_length, [51:39] value_length, [59:52] data_byte,
   // [75:60] new_limit, [79:76] zero
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] status, [15:3] name_length_out, [28:16] value_length_out,
   // [36:29] byte_out, [39:37] zero
   output logic [39:0]      rsp_tdata
);
   import hftf_pkg::*;

   state_type state_ff, state_in;

   // latched request
   logic [2:0]  cmd_ff, cmd_in;
   logic [9:0]  idx_ff, idx_in;
   logic        part_ff, part_in;
   logic [11:0] pos_ff, pos_in;
   logic [LEN_W-1:0] nlen_ff, nlen_in, vlen_ff, vlen_in;
   logic [7:0]  dbyte_ff, dbyte_in;
   logic [15:0] lim_ff, lim_in;

   // table state
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [SIZE_W-1:0]   used_ff, used_in;
   logic [SIZE_W-1:0]   acc_ff, acc_in;
   logic [SIZE_W-1:0]   limit_ff, limit_in;
   logic [TOTAL_W-1:0]  rem_ff, rem_in;
   logic                dropping_ff, dropping_in;
   logic [ARENA_AW-1:0] head_ff, head_in;
   logic [ENTRY_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic                force_ff, force_in;

   // staged result and output register
   logic [2:0]       res_st_ff, res_st_in;
   logic [LEN_W-1:0] res_nl_ff, res_nl_in, res_vl_ff, res_vl_in;
   logic [7:0]       res_b_ff, res_b_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [39:0]      rsp_data_ff, rsp_data_in;

   // memory ports
   arena_wr_type        arena_wr;
   logic [ARENA_AW-1:0] arena_rd_addr;
   logic [7:0]          arena_rd_data;
   desc_wr_type         desc_wr;
   logic [ENTRY_AW-1:0] desc_rd_addr;
   desc_type            desc_rd;

   hftf_arena u_arena (
      .clock   (clock),
      .wr      (arena_wr),
      .rd_addr (arena_rd_addr),
      .rd_data (arena_rd_data)
   );

   hftf_desc u_desc (
      .clock   (clock),
      .wr      (desc_wr),
      .rd_addr (desc_rd_addr),
      .rd_data (desc_rd)
   );

   // static table view
   logic [5:0]           rom_k;
   logic [NAME_BITS-1:0] rom_n, rom_v, rom_s;
   logic [SLEN_W-1:0]    rom_nl, rom_vl, rom_len;
   assign rom_k   = 6'(idx_ff - 10'd1);
   assign rom_n   = rom_name(rom_k);
   assign rom_v   = rom_value(rom_k);
   assign rom_nl  = str_len(rom_n);
   assign rom_vl  = str_len(rom_v);
   assign rom_s   = part_ff ? rom_v : rom_n;
   assign rom_len = part_ff ? rom_vl : rom_nl;

   // insert sizes and the shared size compare unit
   logic [TOTAL_W-1:0] total;
   logic [COST_W-1:0]  cost;
   logic [SUM_W-1:0]   cmp_lhs;
   logic               over, cost_big, is_resize;
   logic [SLOT_W-1:0]  slot;
   assign total     = TOTAL_W'(nlen_ff) + TOTAL_W'(vlen_ff);
   assign cost      = COST_W'(total) + COST_W'(ENTRY_OVERHEAD);
   assign is_resize = (cmd_ff == CMD_RESIZE);
   assign cmp_lhs   = SUM_W'(acc_ff) + (is_resize ? SUM_W'(0) : SUM_W'(cost));
   assign over      = cmp_lhs > SUM_W'(limit_ff);
   assign cost_big  = SUM_W'(cost) > SUM_W'(limit_ff);
   assign slot      = SLOT_W'(idx_ff) - SLOT_W'(FIRST_DYNAMIC);

   // evicted entry sizes
   logic [TOTAL_W-1:0] freed;
   logic [SUM_W-1:0]   freed_cost;
   assign freed      = TOTAL_W'(desc_rd.name_bytes) + TOTAL_W'(desc_rd.value_bytes);
   assign freed_cost = SUM_W'(freed) + SUM_W'(ENTRY_OVERHEAD);

   // selected dynamic part
   logic [LEN_W-1:0] dyn_len;
   assign dyn_len = part_ff ? desc_rd.value_bytes : desc_rd.name_bytes;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (!(rem_ff != '0 && cmd_ff != CMD_INS_BYTE)) begin
               case (cmd_ff)
                  CMD_LOOKUP, CMD_READ: begin
                     if (idx_ff > 10'(STATIC_COUNT) &&
                         slot < SLOT_W'(live_ff)) state_in = S_DUSE;
                  end
                  CMD_INS_BEGIN: state_in = S_EVICT;
                  CMD_RESIZE: begin
                     if ({1'b0, lim_ff} <= 17'(ARENA_BYTES)) state_in = S_EVICT;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_DUSE: begin
            if (cmd_ff == CMD_READ && 13'(pos_ff) < dyn_len) state_in = S_AUSE;
            else state_in = S_RESP;
         end
         S_AUSE: state_in = S_RESP;
         S_EVICT: begin
            if (live_ff != '0 && over) state_in = S_EV_APPLY;
            else if (is_resize || cost_big) state_in = S_RESP;
            else if (live_ff == CNT_W'(MAX_ENTRIES)) state_in = S_EV_APPLY;
            else state_in = S_COMMIT;
         end
         S_EV_APPLY: state_in = force_ff ? S_COMMIT : S_EVICT;
         S_COMMIT:   state_in = S_RESP;
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory port control
   always_comb begin
      cmd_in = cmd_ff; idx_in = idx_ff; part_in = part_ff; pos_in = pos_ff;
      nlen_in = nlen_ff; vlen_in = vlen_ff; dbyte_in = dbyte_ff; lim_in = lim_ff;
      live_in = live_ff; used_in = used_ff; acc_in = acc_ff; limit_in = limit_ff;
      rem_in = rem_ff; dropping_in = dropping_ff; head_in = head_ff;
      wr_ptr_in = wr_ptr_ff; force_in = force_ff;
      res_st_in = res_st_ff; res_nl_in = res_nl_ff; res_vl_in = res_vl_ff;
      res_b_in = res_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      arena_wr = '0;
      arena_rd_addr = '0;
      desc_wr = '0;
      desc_rd_addr = wr_ptr_ff - ENTRY_AW'(live_ff);

      case (state_ff)
         // capture the request
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tdata[2:0];
               idx_in   = req_tdata[12:3];
               part_in  = req_tdata[13];
               pos_in   = req_tdata[25:14];
               nlen_in  = req_tdata[38:26];
               vlen_in  = req_tdata[51:39];
               dbyte_in = req_tdata[59:52];
               lim_in   = req_tdata[75:60];
            end
         end
         // decode and run the one-step commands
         S_EXEC: begin
            res_st_in = ST_OK; res_nl_in = '0; res_vl_in = '0; res_b_in = '0;
            force_in = 1'b0;
            desc_rd_addr = wr_ptr_ff - 1'b1 - ENTRY_AW'(slot);
            if (rem_ff != '0 && cmd_ff != CMD_INS_BYTE) begin
               res_st_in = ST_SEQUENCE;
            end else begin
               case (cmd_ff)
                  CMD_LOOKUP, CMD_READ: begin
                     if (idx_ff == 10'd0) begin
                        res_st_in = ST_BAD_INDEX;
                     end else if (idx_ff <= 10'(STATIC_COUNT)) begin
                        if (cmd_ff == CMD_LOOKUP) begin
                           res_nl_in = LEN_W'(rom_nl);
                           res_vl_in = LEN_W'(rom_vl);
                        end else if (pos_ff < 12'(rom_len)) begin
                           res_b_in = str_byte(rom_s, rom_len, SLEN_W'(pos_ff));
                        end else begin
                           res_st_in = ST_BAD_INDEX;
                        end
                     end else if (slot >= SLOT_W'(live_ff)) begin
                        res_st_in = ST_BAD_INDEX;
                     end
                  end
                  CMD_INS_BEGIN: ;
                  CMD_INS_BYTE: begin
                     if (rem_ff == '0) begin
                        res_st_in = ST_SEQUENCE;
                     end else begin
                        rem_in = rem_ff - 1'b1;
                        if (dropping_ff) begin
                           res_st_in = ST_DROPPED;
                        end else begin
                           arena_wr.en   = 1'b1;
                           arena_wr.addr = head_ff + ARENA_AW'(used_ff)
                                           - ARENA_AW'(rem_ff);
                           arena_wr.data = dbyte_ff;
                        end
                     end
                  end
                  CMD_RESIZE: begin
                     if ({1'b0, lim_ff} > 17'(ARENA_BYTES)) res_st_in = ST_TOO_LARGE;
                     else limit_in = SIZE_W'(lim_ff);
                  end
                  default: res_st_in = ST_SEQUENCE;
               endcase
            end
         end
         // dynamic descriptor is back
         S_DUSE: begin
            if (cmd_ff == CMD_LOOKUP) begin
               res_nl_in = desc_rd.name_bytes;
               res_vl_in = desc_rd.value_bytes;
            end else if (13'(pos_ff) < dyn_len) begin
               arena_rd_addr = desc_rd.name_addr + ARENA_AW'(pos_ff)
                               + (part_ff ? ARENA_AW'(desc_rd.name_bytes) : '0);
            end else begin
               res_st_in = ST_BAD_INDEX;
            end
         end
         S_AUSE: res_b_in = arena_rd_data;
         // eviction loop check, oldest descriptor read is issued here
         S_EVICT: begin
            if (!(live_ff != '0 && over)) begin
               if (is_resize) begin
                  res_st_in = ST_OK;
               end else if (cost_big) begin
                  res_st_in   = ST_DROPPED;
                  dropping_in = 1'b1;
                  rem_in      = total;
               end else if (live_ff == CNT_W'(MAX_ENTRIES)) begin
                  force_in = 1'b1;
               end
            end
         end
         // drop the oldest entry
         S_EV_APPLY: begin
            head_in = head_ff + ARENA_AW'(freed);
            used_in = used_ff - SIZE_W'(freed);
            acc_in  = (SUM_W'(acc_ff) > freed_cost) ?
                      SIZE_W'(SUM_W'(acc_ff) - freed_cost) : '0;
            live_in = live_ff - 1'b1;
         end
         // append the new entry
         S_COMMIT: begin
            desc_wr.en              = 1'b1;
            desc_wr.addr            = wr_ptr_ff;
            desc_wr.data.name_addr  = head_ff + ARENA_AW'(used_ff);
            desc_wr.data.name_bytes  = nlen_ff;
            desc_wr.data.value_bytes = vlen_ff;
            wr_ptr_in   = wr_ptr_ff + 1'b1;
            live_in     = live_ff + 1'b1;
            used_in     = used_ff + SIZE_W'(total);
            acc_in      = acc_ff + SIZE_W'(cost);
            dropping_in = 1'b0;
            rem_in      = total;
            res_st_in   = ST_OK;
         end
         // hand the result to the output register
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_b_ff, res_vl_ff, res_nl_ff, res_st_ff};
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         used_ff      <= '0;
         acc_ff       <= '0;
         limit_ff     <= SIZE_W'(ARENA_BYTES);
         rem_ff       <= '0;
         dropping_ff  <= 1'b0;
         head_ff      <= '0;
         wr_ptr_ff    <= '0;
         force_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         used_ff      <= used_in;
         acc_ff       <= acc_in;
         limit_ff     <= limit_in;
         rem_ff       <= rem_in;
         dropping_ff  <= dropping_in;
         head_ff      <= head_in;
         wr_ptr_ff    <= wr_ptr_in;
         force_ff     <= force_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      part_ff     <= part_in;
      pos_ff      <= pos_in;
      nlen_ff     <= nlen_in;
      vlen_ff     <= vlen_in;
      dbyte_ff    <= dbyte_in;
      lim_ff      <= lim_in;
      res_st_ff   <= res_st_in;
      res_nl_ff   <= res_nl_in;
      res_vl_ff   <= res_vl_in;
      res_b_ff    <= res_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
